@@ sv/sfrc_pkg.sv @@
`timescale 1ns / 1ps

package sfrc_pkg;

    // field widths of the channels
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OFFSET_W = 6;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // register field widths
    localparam int unsigned FLEN_W = 7;
    localparam int unsigned MLEN_W = 3;
    localparam int unsigned MARK_W = 32;

    // longest header or tail that is compared
    localparam logic [MLEN_W-1:0] MAX_MARK = 3'd4;

    // reflected crc-8 polynomial
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

    // register defaults
    localparam logic [FLEN_W-1:0] FLEN_RESET = 7'd8;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_LENGTH  = 3'd0,
        CFG_HEADER_LENGTH = 3'd1,
        CFG_HEADER_BYTES  = 3'd2,
        CFG_TAIL_LENGTH   = 3'd3,
        CFG_TAIL_BYTES    = 3'd4,
        CFG_CRC_POSITION  = 3'd5,
        CFG_CRC_ENABLE    = 3'd6
    } t_cfg_idx;

    // frame status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_PENDING  = 3'd0,
        ST_OK       = 3'd1,
        ST_HDR_BAD  = 3'd2,
        ST_TAIL_BAD = 3'd3,
        ST_CRC_BAD  = 3'd4
    } t_status;

    // one result beat
    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [BYTE_W-1:0]   data_byte;
        logic                is_payload;
        logic                frame_done;
        logic [STATUS_W-1:0] frame_status;
    } t_result;

endpackage

@@ sv/sfrc_rx_if.sv @@
`timescale 1ns / 1ps

interface sfrc_rx_if;
    logic                       valid;
    logic                       ready;
    logic [sfrc_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ sv/sfrc_res_if.sv @@
`timescale 1ns / 1ps

interface sfrc_res_if;
    logic                          valid;
    logic                          ready;
    logic [sfrc_pkg::OFFSET_W-1:0] byte_offset;
    logic [sfrc_pkg::BYTE_W-1:0]   data_byte;
    logic                          is_payload;
    logic                          frame_done;
    logic [sfrc_pkg::STATUS_W-1:0] frame_status;

    modport source (output valid, output byte_offset, output data_byte, output is_payload,
                    output frame_done, output frame_status, input ready);
    modport sink   (input valid, input byte_offset, input data_byte, input is_payload,
                    input frame_done, input frame_status, output ready);
endinterface

@@ sv/sfrc_cfg_if.sv @@
`timescale 1ns / 1ps

interface sfrc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sfrc_pkg::CFG_IDX_W-1:0]  index;
    logic [sfrc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/serial_frame_receive_checker_core.sv @@
`timescale 1ns / 1ps
// a result beat is registered from its accepted byte into the head slot, or into the skid slot while the head waits
// throughput: one byte per cycle while the skid slot is free, bounded by the combinational unrolled crc-8 byte step
// a two-entry output buffer keeps input ready while a result waits downstream
// reset (synchronous, active low): registers return to defaults, frame state
// clears, output buffer empties; no clearing pass, ready right after reset

module serial_frame_receive_checker_core #(
    parameter int unsigned MAX_FRAME = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfrc_rx_if.sink    i_rx,
    sfrc_cfg_if.sink   i_cfg,
    sfrc_res_if.source o_res
);
    import sfrc_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_FRAME);
    localparam int unsigned CW    = (POS_W >= FLEN_W) ? POS_W + 1 : FLEN_W + 1;
    localparam logic [CW-1:0] FRAME_MAX = CW'(MAX_FRAME);

    // configuration registers
    logic [FLEN_W-1:0]   r_frame_length;
    logic [MLEN_W-1:0]   r_header_length;
    logic [MARK_W-1:0]   r_header_bytes;
    logic [MLEN_W-1:0]   r_tail_length;
    logic [MARK_W-1:0]   r_tail_bytes;
    logic [OFFSET_W-1:0] r_crc_position;
    logic                r_crc_enable;

    // frame state
    logic [POS_W-1:0]  r_pos;
    logic [BYTE_W-1:0] r_crc;
    logic              r_crc_ok;
    logic              r_hdr_bad;
    logic              r_tail_bad;
    logic [POS_W-1:0]  n_pos;
    logic [BYTE_W-1:0] n_crc;
    logic              n_crc_ok;
    logic              n_hdr_bad;
    logic              n_tail_bad;

    // output buffer: head slot and skid slot
    logic    r_ov;
    logic    r_sv;
    t_result r_ores;
    t_result r_sres;
    t_result n_res;

    logic in_fire;
    logic out_fire;

    // per-beat decode
    logic [CW-1:0]     flen;
    logic [CW-1:0]     hlen;
    logic [CW-1:0]     tlen;
    logic [CW-1:0]     tail_start;
    logic [CW-1:0]     pos;
    logic [CW-1:0]     tail_idx;
    logic [BYTE_W-1:0] hdr_exp;
    logic [BYTE_W-1:0] tail_exp;
    logic              in_header;
    logic              in_tail;
    logic              is_crc;
    logic              last;
    logic [BYTE_W-1:0] crc_step;
    t_status           status;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = ~r_sv;
    assign in_fire     = i_rx.valid & ~r_sv;
    assign out_fire    = r_ov & o_res.ready;

    // crc-8 over one byte, lsb first
    function automatic logic [BYTE_W-1:0] crc_byte(input logic [BYTE_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = acc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // effective lengths and region decode
    always_comb begin
        flen = CW'(r_frame_length);
        if (flen == '0) begin
            flen = CW'(1);
        end else if (flen > FRAME_MAX) begin
            flen = FRAME_MAX;
        end
        hlen = (r_header_length > MAX_MARK) ? CW'(MAX_MARK) : CW'(r_header_length);
        tlen = (r_tail_length > MAX_MARK) ? CW'(MAX_MARK) : CW'(r_tail_length);
        if (tlen > flen) begin
            tlen = flen;
        end
        tail_start = flen - tlen;
        pos        = CW'(r_pos);
        tail_idx   = pos - tail_start;

        in_header = pos < hlen;
        in_tail   = (pos >= tail_start) && (pos < flen);
        is_crc    = r_crc_enable && (pos == CW'(r_crc_position));
        last      = (pos + CW'(1)) >= flen;

        hdr_exp  = r_header_bytes[pos[1:0]*BYTE_W +: BYTE_W];
        tail_exp = r_tail_bytes[tail_idx[1:0]*BYTE_W +: BYTE_W];
        crc_step = crc_byte(r_crc, i_rx.rx_byte);
    end

    // next frame state and result
    always_comb begin
        n_hdr_bad  = r_hdr_bad  | (in_header && (i_rx.rx_byte != hdr_exp));
        n_tail_bad = r_tail_bad | (in_tail && (i_rx.rx_byte != tail_exp));
        n_crc_ok   = r_crc_ok & ~(is_crc && (i_rx.rx_byte != r_crc));
        n_crc      = (pos < CW'(r_crc_position)) ? crc_step : r_crc;
        n_pos      = r_pos + POS_W'(1);

        if (!last) begin
            status = ST_PENDING;
        end else if (n_hdr_bad) begin
            status = ST_HDR_BAD;
        end else if (n_tail_bad) begin
            status = ST_TAIL_BAD;
        end else if (!n_crc_ok) begin
            status = ST_CRC_BAD;
        end else begin
            status = ST_OK;
        end

        n_res.byte_offset  = OFFSET_W'(r_pos);
        n_res.data_byte    = i_rx.rx_byte;
        n_res.is_payload   = ~(in_header | in_tail | is_crc);
        n_res.frame_done   = last;
        n_res.frame_status = status;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length  <= FLEN_RESET;
            r_header_length <= '0;
            r_header_bytes  <= '0;
            r_tail_length   <= '0;
            r_tail_bytes    <= '0;
            r_crc_position  <= '0;
            r_crc_enable    <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FRAME_LENGTH:  r_frame_length  <= i_cfg.data[FLEN_W-1:0];
                CFG_HEADER_LENGTH: r_header_length <= i_cfg.data[MLEN_W-1:0];
                CFG_HEADER_BYTES:  r_header_bytes  <= i_cfg.data[MARK_W-1:0];
                CFG_TAIL_LENGTH:   r_tail_length   <= i_cfg.data[MLEN_W-1:0];
                CFG_TAIL_BYTES:    r_tail_bytes    <= i_cfg.data[MARK_W-1:0];
                CFG_CRC_POSITION:  r_crc_position  <= i_cfg.data[OFFSET_W-1:0];
                CFG_CRC_ENABLE:    r_crc_enable    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // frame state update, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_crc      <= '0;
            r_crc_ok   <= 1'b1;
            r_hdr_bad  <= 1'b0;
            r_tail_bad <= 1'b0;
        end else if (in_fire) begin
            if (last) begin
                r_pos      <= '0;
                r_crc      <= '0;
                r_crc_ok   <= 1'b1;
                r_hdr_bad  <= 1'b0;
                r_tail_bad <= 1'b0;
            end else begin
                r_pos      <= n_pos;
                r_crc      <= n_crc;
                r_crc_ok   <= n_crc_ok;
                r_hdr_bad  <= n_hdr_bad;
                r_tail_bad <= n_tail_bad;
            end
        end
    end

    // output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (out_fire || !r_ov) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= in_fire;
            end else begin
                r_ov <= in_fire;
            end
        end else if (in_fire) begin
            r_sv <= 1'b1;
        end
    end

    // output buffer data
    always_ff @(posedge i_clk) begin
        if (out_fire || !r_ov) begin
            if (r_sv) begin
                r_ores <= r_sres;
                if (in_fire) begin
                    r_sres <= n_res;
                end
            end else if (in_fire) begin
                r_ores <= n_res;
            end
        end else if (in_fire) begin
            r_sres <= n_res;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.byte_offset  = r_ores.byte_offset;
    assign o_res.data_byte    = r_ores.data_byte;
    assign o_res.is_payload   = r_ores.is_payload;
    assign o_res.frame_done   = r_ores.frame_done;
    assign o_res.frame_status = r_ores.frame_status;

endmodule

@@ tb/serial_frame_receive_checker_core_tb.sv @@
`timescale 1ns / 1ps

module serial_frame_receive_checker_core_tb;

    import sfrc_pkg::*;

    localparam int unsigned FRAME_CAP   = 64;
    localparam int unsigned ITEMS       = 1350;
    localparam int unsigned CALM_ITEMS  = 200;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned DRAIN       = 8;

    // shadow of the checker: registers, frame state and the result beats still due
    class frame_check_board;
        logic [FLEN_W-1:0]   frame_length;
        logic [MLEN_W-1:0]   header_length;
        logic [MARK_W-1:0]   header_bytes;
        logic [MLEN_W-1:0]   tail_length;
        logic [MARK_W-1:0]   tail_bytes;
        logic [OFFSET_W-1:0] crc_position;
        logic                crc_enable;

        int unsigned       position;
        logic [BYTE_W-1:0] crc_acc;
        bit                crc_ok;
        bit                header_bad;
        bit                tail_bad;

        t_result     due_beats[$];
        int unsigned faults;

        function new();
            frame_length  = FLEN_RESET;
            header_length = '0;
            header_bytes  = '0;
            tail_length   = '0;
            tail_bytes    = '0;
            crc_position  = '0;
            crc_enable    = 1'b0;
            faults        = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            position   = 0;
            crc_acc    = '0;
            crc_ok     = 1'b1;
            header_bad = 1'b0;
            tail_bad   = 1'b0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_FRAME_LENGTH:  frame_length  = d[FLEN_W-1:0];
                CFG_HEADER_LENGTH: header_length = d[MLEN_W-1:0];
                CFG_HEADER_BYTES:  header_bytes  = d[MARK_W-1:0];
                CFG_TAIL_LENGTH:   tail_length   = d[MLEN_W-1:0];
                CFG_TAIL_BYTES:    tail_bytes    = d[MARK_W-1:0];
                CFG_CRC_POSITION:  crc_position  = d[OFFSET_W-1:0];
                CFG_CRC_ENABLE:    crc_enable    = d[0];
                default: ;
            endcase
        endfunction

        // reflected crc-8, one byte, lsb first
        static function logic [BYTE_W-1:0] crc_step(logic [BYTE_W-1:0] acc,
                                                    logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] c;
            c = acc ^ b;
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        // role of the byte at offset pos under the current registers
        function void locate(input int unsigned pos, output bit in_hdr, output bit in_tail,
                             output bit is_crc, output bit last,
                             output logic [BYTE_W-1:0] hbyte, output logic [BYTE_W-1:0] tbyte);
            int unsigned flen;
            int unsigned hlen;
            int unsigned tlen;
            int unsigned tstart;
            flen = frame_length;
            if (flen == 0) flen = 1;
            if (flen > FRAME_CAP) flen = FRAME_CAP;
            hlen = (header_length > MAX_MARK) ? MAX_MARK : header_length;
            tlen = (tail_length > MAX_MARK) ? MAX_MARK : tail_length;
            if (tlen > flen) tlen = flen;
            tstart  = flen - tlen;
            in_hdr  = pos < hlen;
            in_tail = pos >= tstart && pos < flen;
            is_crc  = crc_enable && pos == crc_position;
            last    = pos + 1 >= flen;
            // header bytes past the fourth read as zero; the capped header length never reaches them
            hbyte = (pos < 4) ? header_bytes[8*pos +: 8] : '0;
            tbyte = (pos - tstart < 4) ? tail_bytes[8*(pos - tstart) +: 8] : '0;
        endfunction

        // accepted input byte: advance the frame state and queue its result beat
        function void note_byte(logic [BYTE_W-1:0] b);
            bit                in_hdr;
            bit                in_tail;
            bit                is_crc;
            bit                last;
            logic [BYTE_W-1:0] hbyte;
            logic [BYTE_W-1:0] tbyte;
            t_result           r;
            locate(position, in_hdr, in_tail, is_crc, last, hbyte, tbyte);
            if (in_hdr && b != hbyte) header_bad = 1'b1;
            if (in_tail && b != tbyte) tail_bad = 1'b1;
            if (is_crc && b != crc_acc) crc_ok = 1'b0;
            if (position < crc_position) crc_acc = crc_step(crc_acc, b);
            r.byte_offset  = position[OFFSET_W-1:0];
            r.data_byte    = b;
            r.is_payload   = !(in_hdr || in_tail || is_crc);
            r.frame_done   = last;
            r.frame_status = ST_PENDING;
            // header beats tail beats crc
            if (last) begin
                if (header_bad) r.frame_status = ST_HDR_BAD;
                else if (tail_bad) r.frame_status = ST_TAIL_BAD;
                else if (!crc_ok) r.frame_status = ST_CRC_BAD;
                else r.frame_status = ST_OK;
            end
            due_beats = {due_beats, r};
            if (last) clear_frame();
            else position++;
        endfunction

        // accepted result beat against the oldest one due
        function void check_result(t_result got);
            t_result want;
            if (due_beats.size() == 0) begin
                $error("unexpected result beat: offset %0d data %02h", got.byte_offset,
                       got.data_byte);
                faults++;
                return;
            end
            want = due_beats.pop_front();
            if (got.byte_offset !== want.byte_offset) begin
                $error("byte_offset: expected %0d, got %0d", want.byte_offset, got.byte_offset);
                faults++;
            end
            if (got.data_byte !== want.data_byte) begin
                $error("data_byte: expected %02h, got %02h", want.data_byte, got.data_byte);
                faults++;
            end
            if (got.is_payload !== want.is_payload) begin
                $error("is_payload: expected %0b, got %0b", want.is_payload, got.is_payload);
                faults++;
            end
            if (got.frame_done !== want.frame_done) begin
                $error("frame_done: expected %0b, got %0b", want.frame_done, got.frame_done);
                faults++;
            end
            if (got.frame_status !== want.frame_status) begin
                $error("frame_status: expected %0d, got %0d", want.frame_status,
                       got.frame_status);
                faults++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    sfrc_rx_if  rx ();
    sfrc_cfg_if cfg ();
    sfrc_res_if res ();

    frame_check_board sb = new();

    int unsigned sent = 0;
    int unsigned quiet_cycles = 0;
    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b0;
    bit          hold_req = 1'b0;

    serial_frame_receive_checker_core #(
        .MAX_FRAME(FRAME_CAP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx),
        .i_cfg  (cfg),
        .o_res  (res)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog: cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((rx.valid && rx.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: check each beat, random stalls and one long hold-off
    initial begin : result_side
        int unsigned hold;
        t_result     got;
        hold = 0;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res.valid && res.ready) begin
                got.byte_offset  = res.byte_offset;
                got.data_byte    = res.data_byte;
                got.is_payload   = res.is_payload;
                got.frame_done   = res.frame_done;
                got.frame_status = res.frame_status;
                sb.check_result(got);
            end
            if (hold_req) begin
                hold     = LONG_HOLD;
                hold_req = 1'b0;
            end else if (hold != 0) begin
                hold--;
            end else if (rx_idle && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 19);
            end
            res.ready <= (hold == 0);
        end
    end

    // one input beat, with an optional idle burst ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        if (tx_idle && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19);
            rx.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        do @(posedge i_clk); while (!rx.ready);
        sb.note_byte(b);
        sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        do @(posedge i_clk); while (!cfg.ready);
        sb.write_reg(idx, d);
    endtask

    // drain the block, then load all registers
    task automatic configure(input logic [CFG_DATA_W-1:0] flen, input logic [CFG_DATA_W-1:0] hlen,
                             input logic [CFG_DATA_W-1:0] hbytes,
                             input logic [CFG_DATA_W-1:0] tlen,
                             input logic [CFG_DATA_W-1:0] tbytes,
                             input logic [CFG_DATA_W-1:0] cpos,
                             input logic [CFG_DATA_W-1:0] cen);
        rx.valid <= 1'b0;
        while (sb.due_beats.size() != 0) @(posedge i_clk);
        write_reg(CFG_FRAME_LENGTH, flen);
        write_reg(CFG_HEADER_LENGTH, hlen);
        write_reg(CFG_HEADER_BYTES, hbytes);
        write_reg(CFG_TAIL_LENGTH, tlen);
        write_reg(CFG_TAIL_BYTES, tbytes);
        write_reg(CFG_CRC_POSITION, cpos);
        write_reg(CFG_CRC_ENABLE, cen);
        cfg.valid <= 1'b0;
    endtask

    // rest of the current frame, well formed from the present offset on,
    // optionally with one byte spoiled or cut short after some bytes
    task automatic send_frame(input bit spoil, input int unsigned cut);
        logic [BYTE_W-1:0] q[$];
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] hb;
        logic [BYTE_W-1:0] tb;
        bit                ih;
        bit                it;
        bit                ic;
        bit                lst;
        int unsigned       p;
        int unsigned       n;
        int unsigned       k;
        p   = sb.position;
        acc = sb.crc_acc;
        do begin
            sb.locate(p, ih, it, ic, lst, hb, tb);
            b = BYTE_W'($urandom);
            if (it) b = tb;
            // where header and tail overlap, either one may win
            if (ih && (!it || $urandom_range(0, 1) == 1)) b = hb;
            if (ic) b = acc;
            if (p < sb.crc_position) acc = frame_check_board::crc_step(acc, b);
            q = {q, b};
            p++;
        end while (!lst);
        if (spoil) begin
            k = $urandom_range(0, q.size() - 1);
            q[k] = q[k] ^ BYTE_W'($urandom_range(1, 255));
        end
        n = (cut != 0 && cut < q.size()) ? cut : q.size();
        for (k = 0; k < n; k++) send_byte(q[k]);
    endtask

    initial begin : stimulus
        int unsigned                phase;
        int unsigned                nframes;
        bit                         calm;
        logic [CFG_DATA_W-1:0]      flen;
        logic [CFG_DATA_W-1:0]      cpos;
        rx.valid   <= 1'b0;
        rx.rx_byte <= '0;
        cfg.valid  <= 1'b0;
        cfg.index  <= '0;
        cfg.data   <= '0;
        i_rst_n    <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: eight payload bytes, extreme values
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFE);

        // zero length frame, oversized marks, tail cut to frame, crc on a mark byte
        configure(0, 7, 32'h0000_00A5, 7, 32'h0000_005A, 0, 1);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h00);

        // header and tail overlap, crc byte inside the tail, then a partial frame
        configure(5, 2, 32'h0000_C33C, 4, 32'hA596_5AC3, 2, 1);
        send_frame(1'b0, 0);
        send_frame(1'b0, 2);

        // shorter frame mid-frame ends it at once; crc byte beyond the frame
        configure(2, 0, 0, 0, 0, 63, 1);
        send_frame(1'b0, 0);
        send_frame(1'b0, 0);

        // random phases: mostly well formed frames, some spoiled, some noise
        phase = 0;
        while (sent < ITEMS) begin
            phase++;
            calm    = sent + CALM_ITEMS > ITEMS;
            tx_idle = !calm && $urandom_range(0, 2) != 0;
            rx_idle = !calm && $urandom_range(0, 2) != 0;
            case ($urandom_range(0, 11))
                0:       flen = 0;
                1:       flen = FRAME_CAP;
                2:       flen = $urandom_range(FRAME_CAP + 1, 127);
                3, 4:    flen = $urandom_range(13, FRAME_CAP - 1);
                default: flen = $urandom_range(1, 12);
            endcase
            if ($urandom_range(0, 3) == 0) cpos = $urandom_range(0, 63);
            else cpos = $urandom_range(0, (flen > 63) ? 63 : flen);
            configure(flen, $urandom_range(0, 7), $urandom, $urandom_range(0, 7), $urandom,
                      cpos, $urandom_range(0, 1));
            // long receiver hold-off so the block backs up into its input
            if (phase == 6) hold_req = 1'b1;
            nframes = $urandom_range(1, 6);
            repeat (nframes) begin
                case ($urandom_range(0, 9))
                    0: repeat ($urandom_range(1, 12)) send_byte(BYTE_W'($urandom));
                    1, 2: send_frame(1'b1, 0);
                    default: send_frame(1'b0, 0);
                endcase
            end
            if ($urandom_range(0, 3) == 0) send_frame(1'b0, $urandom_range(1, 6));
        end

        // drain and report
        rx.valid <= 1'b0;
        while (sb.due_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (sb.faults == 0 && sb.due_beats.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/sfrc_pkg.sv
sv/sfrc_rx_if.sv
sv/sfrc_res_if.sv
sv/sfrc_cfg_if.sv
sv/serial_frame_receive_checker_core.sv
tb/serial_frame_receive_checker_core_tb.sv
